// ===== hw/rtl/bce_pkg.sv =====
// Bezier curve evaluator: shared widths, codes and pipeline payload types.
// Used by every other file of the block; depends on nothing.
package bce_pkg;

	// Field widths
	localparam int VALUE_WIDTH        = 16;
	localparam int TIME_WIDTH         = 16;
	localparam int FRACTION_BITS      = 16;
	localparam int GOAL_WIDTH         = 15;
	localparam int DEGREE_WIDTH       = 3;
	localparam int GUARD_BITS         = 6;
	localparam int MAX_DEGREE         = 4;
	localparam int NUM_POINTS         = MAX_DEGREE + 1;
	localparam int NUM_REGS           = 7;
	localparam int REG_IDX_WIDTH      = $clog2(NUM_REGS);
	localparam int CFG_DATA_WIDTH     = (VALUE_WIDTH > GOAL_WIDTH) ? VALUE_WIDTH : GOAL_WIDTH;

	// Internal widths
	localparam int CMP_WIDTH          = (TIME_WIDTH - 1 > GOAL_WIDTH) ? TIME_WIDTH - 1 : GOAL_WIDTH;
	localparam int PT_WIDTH           = VALUE_WIDTH + GUARD_BITS;
	localparam int PROD_WIDTH         = PT_WIDTH + FRACTION_BITS + 2;
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES         = (FRACTION_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

	// Register indexes on the configuration port
	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_DEGREE    = REG_IDX_WIDTH'(0),
		REG_GOAL_TIME = REG_IDX_WIDTH'(1),
		REG_START     = REG_IDX_WIDTH'(2),
		REG_CONTROL_1 = REG_IDX_WIDTH'(3),
		REG_CONTROL_2 = REG_IDX_WIDTH'(4),
		REG_CONTROL_3 = REG_IDX_WIDTH'(5),
		REG_END       = REG_IDX_WIDTH'(6)
	} reg_idx_t;

	// Phase codes on the result
	typedef enum logic [1:0] {
		PH_CURVE  = 2'd0,
		PH_BEFORE = 2'd1,
		PH_END    = 2'd2
	} phase_t;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic signed [PT_WIDTH-1:0]    pt_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [PROD_WIDTH:0]    sum_t;
	typedef logic signed [PT_WIDTH:0]      fin_t;

	localparam fin_t VAL_MAX = fin_t'((2 ** (VALUE_WIDTH - 1)) - 1);
	localparam fin_t VAL_MIN = -VAL_MAX - fin_t'(1);

	// Divider stage payload
	typedef struct packed {
		phase_t                  phase;
		value_t                  val;
		logic [GOAL_WIDTH-1:0]   rem;
		logic [FRACTION_BITS-1:0] quo;
	} div_t;

	// De Casteljau level payload
	typedef struct packed {
		phase_t                   phase;
		value_t                   val;
		logic [FRACTION_BITS-1:0] frac;
		pt_t [NUM_POINTS-1:0]     pts;
	} lerp_t;

	// Payload between multiply and sum stages of one level
	typedef struct packed {
		phase_t                   phase;
		value_t                   val;
		logic [FRACTION_BITS-1:0] frac;
		pt_t [NUM_POINTS-1:0]     pts;
		prod_t [MAX_DEGREE-1:0]   pa;
		prod_t [MAX_DEGREE-1:0]   pb;
	} mul_t;

endpackage

// ===== hw/rtl/bce_if.sv =====
// Bezier curve evaluator: channel interfaces for samples, results and config.
// Depends on bce_pkg for field widths.

interface bce_sample_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [bce_pkg::TIME_WIDTH-1:0]    sample_time;

	modport source (output valid, output sample_time, input ready);
	modport sink   (input valid, input sample_time, output ready);
endinterface

interface bce_result_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [bce_pkg::VALUE_WIDTH-1:0]   curve_value;
	logic [1:0]                               phase;

	modport source (output valid, output curve_value, output phase, input ready);
	modport sink   (input valid, input curve_value, input phase, output ready);
endinterface

interface bce_cfg_if;
	logic                                     valid;
	logic                                     ready;
	logic [bce_pkg::REG_IDX_WIDTH-1:0]        index;
	logic [bce_pkg::CFG_DATA_WIDTH-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bce_div.sv =====
// Bezier curve evaluator: pipelined restoring divider, sample_time / goal_time.
// DIV_BITS_PER_STAGE quotient bits per stage. Depends on bce_pkg.
module bce_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bce_pkg::GOAL_WIDTH-1:0]      goal,
	input  bce_pkg::div_t                       in_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	output bce_pkg::div_t                       out_data,
	output logic                                out_valid,
	input  logic                                out_ready
);

	logic [bce_pkg::DIV_STAGES-1:0] div_vld_s;
	bce_pkg::div_t                  div_dat_s [bce_pkg::DIV_STAGES];
	bce_pkg::div_t                  stg_in    [bce_pkg::DIV_STAGES];
	bce_pkg::div_t                  stg_nxt   [bce_pkg::DIV_STAGES];
	logic [bce_pkg::DIV_STAGES-1:0] stg_vin;
	logic [bce_pkg::DIV_STAGES:0]   stg_rdy;

	// Stage inputs
	always_comb begin
		stg_in[0]  = in_data;
		stg_vin[0] = in_valid;
		for (int k = 1; k < bce_pkg::DIV_STAGES; k++) begin
			stg_in[k]  = div_dat_s[k-1];
			stg_vin[k] = div_vld_s[k-1];
		end
	end

	// Compare-subtract steps; the dividend's low bits are zero
	always_comb begin
		bce_pkg::div_t                 d;
		logic [bce_pkg::GOAL_WIDTH:0]  r2;
		logic [bce_pkg::GOAL_WIDTH:0]  g_ext;
		g_ext = {1'b0, goal};
		for (int k = 0; k < bce_pkg::DIV_STAGES; k++) begin
			d = stg_in[k];
			for (int j = 0; j < bce_pkg::DIV_BITS_PER_STAGE; j++) begin
				if (k * bce_pkg::DIV_BITS_PER_STAGE + j < bce_pkg::FRACTION_BITS) begin
					r2 = {d.rem, 1'b0};
					if (r2 >= g_ext) begin
						d.rem = bce_pkg::GOAL_WIDTH'(r2 - g_ext);
						d.quo = {d.quo[bce_pkg::FRACTION_BITS-2:0], 1'b1};
					end else begin
						d.rem = r2[bce_pkg::GOAL_WIDTH-1:0];
						d.quo = {d.quo[bce_pkg::FRACTION_BITS-2:0], 1'b0};
					end
				end
			end
			stg_nxt[k] = d;
		end
	end

	// Per-stage flow control: a stage loads when empty or when drained
	always_comb begin
		stg_rdy[bce_pkg::DIV_STAGES] = out_ready;
		for (int k = bce_pkg::DIV_STAGES - 1; k >= 0; k--) begin
			stg_rdy[k] = !div_vld_s[k] || stg_rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
		end else begin
			for (int k = 0; k < bce_pkg::DIV_STAGES; k++) begin
				if (stg_rdy[k]) begin
					div_vld_s[k] <= stg_vin[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < bce_pkg::DIV_STAGES; k++) begin
			if (stg_rdy[k] && stg_vin[k]) begin
				div_dat_s[k] <= stg_nxt[k];
			end
		end
	end

	assign in_ready  = stg_rdy[0];
	assign out_data  = div_dat_s[bce_pkg::DIV_STAGES-1];
	assign out_valid = div_vld_s[bce_pkg::DIV_STAGES-1];

endmodule

// ===== hw/rtl/bce_lerp.sv =====
// Bezier curve evaluator: one de Casteljau level, multiply stage then sum stage.
// Each point i becomes round((p[i]*u + p[i+1]*f) / 2^FRACTION_BITS). Depends on bce_pkg.
module bce_lerp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  bce_pkg::lerp_t    in_data,
	input  logic              in_valid,
	output logic              in_ready,
	output bce_pkg::lerp_t    out_data,
	output logic              out_valid,
	input  logic              out_ready
);

	bce_pkg::mul_t  mul_s1;
	logic           vld_s1;
	bce_pkg::lerp_t lerp_s2;
	logic           vld_s2;

	bce_pkg::mul_t  mul_nxt;
	bce_pkg::lerp_t lerp_nxt;
	logic           rdy_s1;
	logic           rdy_s2;

	// Multiply: weights u = 1 - f and f
	always_comb begin
		logic [bce_pkg::FRACTION_BITS:0] u;
		bce_pkg::prod_t                  u_ext;
		bce_pkg::prod_t                  f_ext;
		u = {1'b1, bce_pkg::FRACTION_BITS'(0)} - {1'b0, in_data.frac};
		u_ext = bce_pkg::prod_t'(u);
		f_ext = bce_pkg::prod_t'(in_data.frac);
		mul_nxt.phase = in_data.phase;
		mul_nxt.val   = in_data.val;
		mul_nxt.frac  = in_data.frac;
		mul_nxt.pts   = in_data.pts;
		for (int i = 0; i < bce_pkg::MAX_DEGREE; i++) begin
			mul_nxt.pa[i] = bce_pkg::prod_t'(in_data.pts[i]) * u_ext;
			mul_nxt.pb[i] = bce_pkg::prod_t'(in_data.pts[i+1]) * f_ext;
		end
	end

	// Sum and round to nearest; a level past the degree passes its points
	always_comb begin
		bce_pkg::sum_t sum;
		bce_pkg::sum_t rnd;
		lerp_nxt.phase = mul_s1.phase;
		lerp_nxt.val   = mul_s1.val;
		lerp_nxt.frac  = mul_s1.frac;
		lerp_nxt.pts   = mul_s1.pts;
		for (int i = 0; i < bce_pkg::MAX_DEGREE; i++) begin
			sum = bce_pkg::sum_t'(mul_s1.pa[i]) + bce_pkg::sum_t'(mul_s1.pb[i]);
			rnd = (sum + (bce_pkg::sum_t'(1) <<< (bce_pkg::FRACTION_BITS - 1)))
				>>> bce_pkg::FRACTION_BITS;
			if (step_en) begin
				lerp_nxt.pts[i] = rnd[bce_pkg::PT_WIDTH-1:0];
			end
		end
	end

	// Flow control
	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mul_s1 <= mul_nxt;
		end
		if (rdy_s2 && vld_s1) begin
			lerp_s2 <= lerp_nxt;
		end
	end

	assign out_data  = lerp_s2;
	assign out_valid = vld_s2;

endmodule

// ===== hw/rtl/bezier_curve_evaluator_core.sv =====
// Bezier curve evaluator, Bernstein degree 0 to 4, one result per sample.
// Path: the divider stages, the multiply and sum stages of each level, then the output register.
// Throughput: one sample per cycle while result.ready is high, set by the fully pipelined divider and levels.
// Reset (arst_n, async): pipeline empties, degree = 1, other registers = 0.
// Depends on bce_pkg, bce_if, bce_div and bce_lerp.
module bezier_curve_evaluator_core (
	input  logic                 clk,
	input  logic                 arst_n,
	bce_cfg_if.sink              cfg,
	bce_sample_if.sink           sample,
	bce_result_if.source         result
);

	logic [bce_pkg::DEGREE_WIDTH-1:0] degree_q;
	logic [bce_pkg::GOAL_WIDTH-1:0]   goal_q;
	bce_pkg::value_t                  point_q [bce_pkg::NUM_POINTS];

	logic [bce_pkg::DEGREE_WIDTH-1:0] deg_n;
	bce_pkg::value_t                  last_pt;
	bce_pkg::pt_t [bce_pkg::NUM_POINTS-1:0] pts_init;

	bce_pkg::div_t                    div_in;
	bce_pkg::div_t                    div_out;
	logic                             div_out_valid;

	bce_pkg::lerp_t                   lp_data  [bce_pkg::MAX_DEGREE+1];
	logic [bce_pkg::MAX_DEGREE:0]     lp_valid;
	logic [bce_pkg::MAX_DEGREE:0]     lp_ready;

	logic                             res_vld_q;
	bce_pkg::value_t                  res_value_q;
	bce_pkg::phase_t                  res_phase_q;
	logic                             res_rdy;
	bce_pkg::value_t                  fin_value;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= bce_pkg::DEGREE_WIDTH'(1);
			goal_q   <= '0;
			for (int i = 0; i < bce_pkg::NUM_POINTS; i++) begin
				point_q[i] <= '0;
			end
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				bce_pkg::REG_DEGREE:    degree_q   <= cfg.data[bce_pkg::DEGREE_WIDTH-1:0];
				bce_pkg::REG_GOAL_TIME: goal_q     <= cfg.data[bce_pkg::GOAL_WIDTH-1:0];
				bce_pkg::REG_START:     point_q[0] <= cfg.data[bce_pkg::VALUE_WIDTH-1:0];
				bce_pkg::REG_CONTROL_1: point_q[1] <= cfg.data[bce_pkg::VALUE_WIDTH-1:0];
				bce_pkg::REG_CONTROL_2: point_q[2] <= cfg.data[bce_pkg::VALUE_WIDTH-1:0];
				bce_pkg::REG_CONTROL_3: point_q[3] <= cfg.data[bce_pkg::VALUE_WIDTH-1:0];
				bce_pkg::REG_END:       point_q[4] <= cfg.data[bce_pkg::VALUE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Saturated degree and the point list for it, scaled by the guard bits
	always_comb begin
		bce_pkg::value_t src;
		deg_n = (degree_q > bce_pkg::DEGREE_WIDTH'(bce_pkg::MAX_DEGREE)) ?
			bce_pkg::DEGREE_WIDTH'(bce_pkg::MAX_DEGREE) : degree_q;
		last_pt = (deg_n == '0) ? point_q[0] : point_q[bce_pkg::MAX_DEGREE];
		for (int j = 0; j < bce_pkg::NUM_POINTS; j++) begin
			if (j == 0) begin
				src = point_q[0];
			end else if (bce_pkg::DEGREE_WIDTH'(j) < deg_n) begin
				src = point_q[j];
			end else begin
				src = point_q[bce_pkg::MAX_DEGREE];
			end
			pts_init[j] = {src, bce_pkg::GUARD_BITS'(0)};
		end
	end

	// Entry: classify the sample and seed the divider
	always_comb begin
		logic [bce_pkg::CMP_WIDTH-1:0] t_mag;
		logic [bce_pkg::CMP_WIDTH-1:0] g_ext;
		t_mag = bce_pkg::CMP_WIDTH'(sample.sample_time[bce_pkg::TIME_WIDTH-2:0]);
		g_ext = bce_pkg::CMP_WIDTH'(goal_q);
		div_in.quo = '0;
		div_in.rem = '0;
		if (goal_q == '0) begin
			div_in.phase = bce_pkg::PH_END;
			div_in.val   = last_pt;
		end else if (sample.sample_time[bce_pkg::TIME_WIDTH-1]) begin
			div_in.phase = bce_pkg::PH_BEFORE;
			div_in.val   = point_q[0];
		end else if (t_mag >= g_ext) begin
			div_in.phase = bce_pkg::PH_END;
			div_in.val   = last_pt;
		end else begin
			div_in.phase = bce_pkg::PH_CURVE;
			div_in.val   = '0;
			div_in.rem   = t_mag[bce_pkg::GOAL_WIDTH-1:0];
		end
	end

	// Factor f = sample_time * 2^FRACTION_BITS / goal_time
	bce_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.goal      (goal_q),
		.in_data   (div_in),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_data  (div_out),
		.out_valid (div_out_valid),
		.out_ready (lp_ready[0])
	);

	assign lp_data[0]  = '{phase: div_out.phase, val: div_out.val, frac: div_out.quo,
		pts: pts_init};
	assign lp_valid[0] = div_out_valid;

	// One level per degree step; levels past the degree pass through
	for (genvar l = 0; l < bce_pkg::MAX_DEGREE; l++) begin : g_level
		bce_lerp u_lerp (
			.clk       (clk),
			.arst_n    (arst_n),
			.step_en   (bce_pkg::DEGREE_WIDTH'(l) < deg_n),
			.in_data   (lp_data[l]),
			.in_valid  (lp_valid[l]),
			.in_ready  (lp_ready[l]),
			.out_data  (lp_data[l+1]),
			.out_valid (lp_valid[l+1]),
			.out_ready (lp_ready[l+1])
		);
	end

	// Drop the guard bits with rounding, clamp, or take the fixed value
	always_comb begin
		bce_pkg::fin_t rnd;
		rnd = (bce_pkg::fin_t'(lp_data[bce_pkg::MAX_DEGREE].pts[0])
			+ bce_pkg::fin_t'(2 ** (bce_pkg::GUARD_BITS - 1))) >>> bce_pkg::GUARD_BITS;
		if (lp_data[bce_pkg::MAX_DEGREE].phase != bce_pkg::PH_CURVE) begin
			fin_value = lp_data[bce_pkg::MAX_DEGREE].val;
		end else if (rnd > bce_pkg::VAL_MAX) begin
			fin_value = bce_pkg::VAL_MAX[bce_pkg::VALUE_WIDTH-1:0];
		end else if (rnd < bce_pkg::VAL_MIN) begin
			fin_value = bce_pkg::VAL_MIN[bce_pkg::VALUE_WIDTH-1:0];
		end else begin
			fin_value = rnd[bce_pkg::VALUE_WIDTH-1:0];
		end
	end

	// Output register
	assign res_rdy                     = !res_vld_q || result.ready;
	assign lp_ready[bce_pkg::MAX_DEGREE] = res_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_rdy) begin
			res_vld_q <= lp_valid[bce_pkg::MAX_DEGREE];
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy && lp_valid[bce_pkg::MAX_DEGREE]) begin
			res_value_q <= fin_value;
			res_phase_q <= lp_data[bce_pkg::MAX_DEGREE].phase;
		end
	end

	assign result.valid       = res_vld_q;
	assign result.curve_value = res_value_q;
	assign result.phase       = res_phase_q;

endmodule

// ===== tb/sv/bezier_curve_evaluator_core_tb.sv =====
// Testbench for bezier_curve_evaluator_core: directed and random sample streams
// checked against an in-bench curve predictor, with random stalls on both channels.
// Depends on bce_pkg, bce_if and the RTL of the evaluator.
module bezier_curve_evaluator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 9;
	localparam int PIPE_LATENCY = bce_pkg::DIV_STAGES + 2 * bce_pkg::MAX_DEGREE + 1;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int IDLE_PERCENT = 18;
	localparam int RANDOM_PHASES = 10;
	localparam int SAMPLES_PER_PHASE = 93;
	localparam int STEADY_PHASE = 5;
	localparam logic [bce_pkg::REG_IDX_WIDTH-1:0] UNUSED_INDEX =
		bce_pkg::REG_IDX_WIDTH'(bce_pkg::NUM_REGS);
	localparam logic [bce_pkg::GOAL_WIDTH-1:0] GOAL_MAX = '1;
	localparam bce_pkg::value_t VALUE_MAX =
		bce_pkg::value_t'((2 ** (bce_pkg::VALUE_WIDTH - 1)) - 1);
	localparam bce_pkg::value_t VALUE_MIN =
		bce_pkg::value_t'(-(2 ** (bce_pkg::VALUE_WIDTH - 1)));

	typedef logic signed [bce_pkg::TIME_WIDTH-1:0] stime_t;
	typedef logic [bce_pkg::CFG_DATA_WIDTH-1:0] cfg_data_t;

	// One expected output of the evaluator
	typedef struct {
		stime_t sample_time;
		bce_pkg::value_t curve_value;
		bce_pkg::phase_t phase;
	} curve_point_t;

	logic clk;
	logic arst_n;
	bit steady;
	int errors;
	int cycles;
	curve_point_t pending_points[$];

	// Mirror of the register file
	logic [bce_pkg::DEGREE_WIDTH-1:0] m_degree;
	logic [bce_pkg::GOAL_WIDTH-1:0] m_goal;
	bce_pkg::value_t m_pts[bce_pkg::NUM_POINTS];

	bce_cfg_if cfg_bus();
	bce_sample_if sample_bus();
	bce_result_if result_bus();

	bezier_curve_evaluator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (sample_bus),
		.result (result_bus)
	);

	always #HALF_PERIOD clk = ~clk;

	// Round to nearest, ties toward plus infinity
	function automatic longint round_half_up(input longint x, input int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Expected curve value and phase for one sample time
	function automatic curve_point_t predict_curve(input stime_t t);
		longint pts[bce_pkg::NUM_POINTS];
		longint frac;
		longint rest;
		longint val;
		int deg;
		int i;
		int lvl;
		curve_point_t r;
		deg = (m_degree > bce_pkg::MAX_DEGREE) ? bce_pkg::MAX_DEGREE : int'(m_degree);
		pts[0] = longint'(m_pts[0]);
		for (i = 1; i < deg; i++)
			pts[i] = longint'(m_pts[i]);
		if (deg > 0)
			pts[deg] = longint'(m_pts[bce_pkg::NUM_POINTS-1]);
		if (m_goal == 0) begin
			r.phase = bce_pkg::PH_END;
			val = pts[deg];
		end else if (t < 0) begin
			r.phase = bce_pkg::PH_BEFORE;
			val = pts[0];
		end else if (longint'(t) >= longint'(m_goal)) begin
			r.phase = bce_pkg::PH_END;
			val = pts[deg];
		end else begin
			r.phase = bce_pkg::PH_CURVE;
			frac = (longint'(t) <<< bce_pkg::FRACTION_BITS) / longint'(m_goal);
			rest = (longint'(1) <<< bce_pkg::FRACTION_BITS) - frac;
			for (i = 0; i <= deg; i++)
				pts[i] = pts[i] * (longint'(1) <<< bce_pkg::GUARD_BITS);
			// de Casteljau levels
			for (lvl = 0; lvl < deg; lvl++)
				for (i = 0; i < deg - lvl; i++)
					pts[i] = round_half_up(pts[i] * rest + pts[i+1] * frac,
						bce_pkg::FRACTION_BITS);
			val = round_half_up(pts[0], bce_pkg::GUARD_BITS);
		end
		if (val > longint'(VALUE_MAX))
			val = longint'(VALUE_MAX);
		if (val < longint'(VALUE_MIN))
			val = longint'(VALUE_MIN);
		r.sample_time = t;
		r.curve_value = bce_pkg::value_t'(val);
		return r;
	endfunction

	// One register write; valid stays high for a following write
	task automatic write_reg(input logic [bce_pkg::REG_IDX_WIDTH-1:0] idx,
			input cfg_data_t data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		case (idx)
			bce_pkg::REG_DEGREE: m_degree = data[bce_pkg::DEGREE_WIDTH-1:0];
			bce_pkg::REG_GOAL_TIME: m_goal = data[bce_pkg::GOAL_WIDTH-1:0];
			bce_pkg::REG_START, bce_pkg::REG_CONTROL_1, bce_pkg::REG_CONTROL_2,
			bce_pkg::REG_CONTROL_3, bce_pkg::REG_END:
				m_pts[idx - bce_pkg::REG_START] = bce_pkg::value_t'(data);
			default: ;
		endcase
	endtask

	// Full curve setup; the pipeline must be drained first
	task automatic load_curve(input cfg_data_t deg_data, input cfg_data_t goal_data,
			input bce_pkg::value_t p0, input bce_pkg::value_t p1,
			input bce_pkg::value_t p2, input bce_pkg::value_t p3,
			input bce_pkg::value_t p4);
		write_reg(bce_pkg::REG_DEGREE, deg_data);
		write_reg(bce_pkg::REG_GOAL_TIME, goal_data);
		write_reg(bce_pkg::REG_START, p0);
		write_reg(bce_pkg::REG_CONTROL_1, p1);
		write_reg(bce_pkg::REG_CONTROL_2, p2);
		write_reg(bce_pkg::REG_CONTROL_3, p3);
		write_reg(bce_pkg::REG_END, p4);
		cfg_bus.valid <= 1'b0;
	endtask

	// Sample transfer with random leading gaps
	task automatic send_sample(input stime_t t);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.sample_time <= t;
		@(posedge clk);
		while (!sample_bus.ready) @(posedge clk);
		pending_points.push_back(predict_curve(t));
	endtask

	// Stop sending and wait until every result is back
	task automatic wait_idle();
		sample_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
	endtask

	function automatic bce_pkg::value_t pick_point(input bit extremes_only);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25 || (extremes_only && roll < 50))
			return VALUE_MIN;
		if (roll < 50 || extremes_only)
			return VALUE_MAX;
		return bce_pkg::value_t'($urandom);
	endfunction

	// Mostly inside the curve, some before start, some past the goal
	function automatic stime_t pick_sample();
		int roll;
		roll = $urandom_range(0, 99);
		if (m_goal == 0 || roll < 10)
			return stime_t'($urandom);
		if (roll < 20)
			return stime_t'($urandom_range(m_goal, GOAL_MAX));
		return stime_t'($urandom_range(0, m_goal - 1));
	endfunction

	// Reset values: degree 1, zero goal, all points zero
	task automatic test_reset_state();
		send_sample(stime_t'(VALUE_MIN));
		send_sample(stime_t'(0));
		send_sample(stime_t'(VALUE_MAX));
	endtask

	// Extreme points and times; goal written with its unused top bit set
	task automatic test_field_extremes();
		wait_idle();
		load_curve(cfg_data_t'(bce_pkg::MAX_DEGREE), '1, VALUE_MIN, VALUE_MAX, VALUE_MIN,
			VALUE_MAX, VALUE_MIN);
		send_sample(stime_t'(VALUE_MIN));
		send_sample(stime_t'(-1));
		send_sample(stime_t'(0));
		send_sample(stime_t'(1));
		send_sample(stime_t'(GOAL_MAX - 1));
		send_sample(stime_t'(GOAL_MAX));
	endtask

	// Every degree code, including the saturated ones above four
	task automatic test_degrees();
		int deg;
		for (deg = 0; deg < 2 ** bce_pkg::DEGREE_WIDTH; deg++) begin
			wait_idle();
			load_curve(cfg_data_t'(deg), cfg_data_t'(100), bce_pkg::value_t'(-1000),
				bce_pkg::value_t'(3000), bce_pkg::value_t'(-2000),
				bce_pkg::value_t'(500), bce_pkg::value_t'(1500));
			send_sample(stime_t'(37));
			// degree zero ignores the end point even past the goal
			if (deg == 0)
				send_sample(stime_t'(200));
		end
	endtask

	// Smallest goals and a write to an index past the register file
	task automatic test_goal_edges();
		wait_idle();
		load_curve(cfg_data_t'(2), cfg_data_t'(1), bce_pkg::value_t'(700),
			bce_pkg::value_t'(-700), bce_pkg::value_t'(0), bce_pkg::value_t'(0),
			bce_pkg::value_t'(300));
		send_sample(stime_t'(0));
		send_sample(stime_t'(1));
		wait_idle();
		write_reg(UNUSED_INDEX, '1);
		write_reg(bce_pkg::REG_GOAL_TIME, cfg_data_t'(2));
		cfg_bus.valid <= 1'b0;
		send_sample(stime_t'(1));
		send_sample(stime_t'(-5));
	endtask

	// Random curves, one setup per phase, one phase without any idling
	task automatic test_random_curves();
		int ph;
		int k;
		logic [bce_pkg::GOAL_WIDTH-1:0] goal;
		cfg_data_t deg_data;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			steady = (ph == STEADY_PHASE);
			case ($urandom_range(0, 3))
				0: goal = bce_pkg::GOAL_WIDTH'($urandom_range(1, 16));
				1: goal = bce_pkg::GOAL_WIDTH'($urandom_range(17, 4095));
				default: goal = bce_pkg::GOAL_WIDTH'($urandom_range(1, GOAL_MAX));
			endcase
			if (ph == 0)
				goal = GOAL_MAX;
			else if (ph == 1)
				goal = '0;
			deg_data = cfg_data_t'($urandom);
			if (ph == 0)
				deg_data = cfg_data_t'(bce_pkg::MAX_DEGREE);
			load_curve(deg_data, {1'($urandom), goal}, pick_point(ph == 0),
				pick_point(ph == 0), pick_point(ph == 0), pick_point(ph == 0),
				pick_point(ph == 0));
			for (k = 0; k < SAMPLES_PER_PHASE; k++)
				send_sample(pick_sample());
		end
		steady = 1'b0;
	endtask

	// Result receiver: random stalls except during the steady phase
	always @(posedge clk) begin
		result_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		curve_point_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_points.size() == 0) begin
				errors++;
				$display("%0t: result with no sample outstanding: expected none, %s %0d %s %0d",
					$time, "actual value", result_bus.curve_value, "phase",
					result_bus.phase);
			end else begin
				want = pending_points.pop_front();
				if (result_bus.curve_value !== want.curve_value) begin
					errors++;
					$display("%0t: curve_value at time %0d: expected %0d, actual %0d",
						$time, want.sample_time, want.curve_value,
						result_bus.curve_value);
				end
				if (result_bus.phase !== want.phase) begin
					errors++;
					$display("%0t: phase at time %0d: expected %0d, actual %0d",
						$time, want.sample_time, want.phase, result_bus.phase);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		errors = 0;
		cycles = 0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		sample_bus.valid = 1'b0;
		sample_bus.sample_time = '0;
		result_bus.ready = 1'b0;
		m_degree = bce_pkg::DEGREE_WIDTH'(1);
		m_goal = '0;
		foreach (m_pts[i])
			m_pts[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_degrees();
		test_goal_edges();
		test_random_curves();

		wait_idle();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
